// File: rtl/hss_pkg.sv
// ----------------------------------------------------------------------------
// hss_pkg: shared types and constants of the height grid smoother
// Holds the channel payload structs, operation codes, register indexes,
// fixed-point constants and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package hss_pkg;

   // Grid geometry default.
   localparam int MaxSideDefault = 64;

   // Field widths.
   localparam int HeightW = 20;
   localparam int CoordW  = 6;
   localparam int OpW     = 2;
   localparam int SideRegW = 7;
   localparam int MaskW   = 4;
   localparam int PassW   = 4;
   localparam int CsrIdxW = 2;

   // Largest Q8.12 height.
   localparam logic [HeightW-1:0] HMax = {HeightW{1'b1}};

   // Weights: 0.75 = 15/20 and 0.6 = 12/20.
   localparam int KOwn = 15;
   localparam int KNbr = 12;
   localparam int KDen = 20;

   // Numerator of the weighted sum and the width of the own weight 15*n.
   localparam int NumW = 28;
   localparam int DenW = 8;

   // Division by 20*n as a multiply by 2^36/(20*n) rounded up, then a shift.
   localparam int RecipW     = 30;
   localparam int RecipShift = 36;
   localparam int ProdW      = NumW + RecipW;
   localparam int QuotW      = ProdW - RecipShift;
   localparam logic [RecipW-1:0] RecipCorner = 30'd858993460;  // divisor 80
   localparam logic [RecipW-1:0] RecipEdge   = 30'd572662307;  // divisor 120
   localparam logic [RecipW-1:0] RecipInner  = 30'd381774871;  // divisor 180

   // Register reset values.
   localparam logic [SideRegW-1:0] SideReset = 7'd64;
   localparam logic [MaskW-1:0]    MaskReset = 4'd0;
   localparam logic [PassW-1:0]    PassReset = 4'd10;

   // Bits of the fixed edge mask.
   localparam int EdgeLeft   = 0;
   localparam int EdgeTop    = 1;
   localparam int EdgeRight  = 2;
   localparam int EdgeBottom = 3;

   // Operation codes.
   localparam logic [OpW-1:0] OpWrite = 2'd0;
   localparam logic [OpW-1:0] OpRun   = 2'd1;
   localparam logic [OpW-1:0] OpRead  = 2'd2;
   localparam logic [OpW-1:0] OpNone  = 2'd3;

   // Register indexes.
   localparam logic [CsrIdxW-1:0] CsrGridSide = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrEdgeMask = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrPasses   = 2'd2;

   typedef struct packed {
      logic [OpW-1:0]     op;
      logic [CoordW-1:0]  col;
      logic [CoordW-1:0]  row;
      logic [HeightW-1:0] height_in;
   } req_type;

   typedef struct packed {
      logic [HeightW-1:0] height_out;
      logic               saturated;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic user_exec;
      logic run_init;
      logic win_read;
      logic div_load;
      logic div_step;
      logic write_back;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OpW-1:0] op;
      logic           pass_zero;
      logic           win_last;
      logic           run_last;
      logic           rsp_free;
   } status_type;

endpackage

// File: rtl/heightmap_stencil_smoother_core.sv
// ----------------------------------------------------------------------------
// heightmap_stencil_smoother_core: height grid smoother top level
// Square grid of Q8.12 heights, loaded and read cell by cell, smoothed by a
// clipped 3x3 weighted stencil over a programmable number of passes.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries write, run and read operations; each one
// produces exactly one transfer on the response channel. Writes and reads
// step from the execute state to the response state, which loads the output
// register once it is free, and the sequencer then returns to idle for the
// next request. A run steps through every cell of every pass in turn: nine
// window reads through the single bank read port, a state to finish the
// window sum, one for the weighted numerator, one reciprocal multiply and a
// write-back.
// One request is worked on at a time; a new request is accepted while the
// previous response still waits in the output register, and a stalled
// receiver holds the next response in the sequencer until the register
// frees. The csr port writes side, fixed edge mask and pass count at any
// edge with csr_we high and should only be used while the block is idle.
// Synchronous reset restores the register defaults and clears the clip
// flag; grid contents are undefined until written.
// ----------------------------------------------------------------------------
module heightmap_stencil_smoother_core #(
   parameter int MAX_SIDE = hss_pkg::MaxSideDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  hss_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output hss_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [hss_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [hss_pkg::SideRegW-1:0]  csr_wdata
);

   hss_pkg::cmd_type    cmd;
   hss_pkg::status_type status;

   // Sequencer.
   hss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   hss_datapath #(
      .MAX_SIDE (MAX_SIDE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

`ifndef SYNTHESIS
   // Only one request is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // The divide step is followed by the write-back of the cell.
   a_div_then_wb: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> cmd.write_back)
      else $error("divider finished without write-back");

   // Window reads, division, write-back and response loading never overlap.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.win_read, cmd.div_step, cmd.write_back, cmd.rsp_load}))
      else $error("overlapping datapath commands");
`endif

endmodule

// File: rtl/hss_ctrl.sv
// ----------------------------------------------------------------------------
// hss_ctrl: sequencer of the height grid smoother
// Steps each request through execution, and a run through window reads,
// weighting, division and write-back for every cell of every pass.
// ----------------------------------------------------------------------------
module hss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hss_pkg::status_type status,
   output hss_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_EXEC  = 8'b0000_0010,
      ST_WIN   = 8'b0000_0100,
      ST_WLAST = 8'b0000_1000,
      ST_MUL   = 8'b0001_0000,
      ST_DIV   = 8'b0010_0000,
      ST_WB    = 8'b0100_0000,
      ST_RESP  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.op == hss_pkg::OpRun) begin
               cmd.run_init = 1'b1;
               state_in     = status.pass_zero ? ST_RESP : ST_WIN;
            end else begin
               cmd.user_exec = 1'b1;
               state_in      = ST_RESP;
            end
         end
         ST_WIN: begin
            cmd.win_read = 1'b1;
            if (status.win_last) begin
               state_in = ST_WLAST;
            end
         end
         ST_WLAST: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = ST_WB;
         end
         ST_WB: begin
            cmd.write_back = 1'b1;
            state_in       = status.run_last ? ST_RESP : ST_WIN;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/hss_datapath.sv
// ----------------------------------------------------------------------------
// hss_datapath: grid memories, counters and arithmetic of the smoother
// Holds two ping-pong grid banks, the configuration registers, the cell and
// window counters, the window accumulators, a reciprocal-multiply divider and
// the response register.
// ----------------------------------------------------------------------------
module hss_datapath #(
   parameter int MAX_SIDE = hss_pkg::MaxSideDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hss_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hss_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [hss_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [hss_pkg::SideRegW-1:0]        csr_wdata,
   input  hss_pkg::cmd_type                    cmd,
   output hss_pkg::status_type                 status
);

   localparam int CW    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
   localparam int AW    = 2 * CW;
   localparam int Depth = 1 << AW;
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int CmpW  = (SW > hss_pkg::SideRegW) ? SW + 1 : hss_pkg::SideRegW + 1;
   localparam int HW    = hss_pkg::HeightW;
   localparam int SumW  = HW + 3;

   // Configuration registers.
   logic [hss_pkg::SideRegW-1:0] grid_side_ff;
   logic [hss_pkg::MaskW-1:0]    edge_mask_ff;
   logic [hss_pkg::PassW-1:0]    pass_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff  <= hss_pkg::SideReset;
         edge_mask_ff  <= hss_pkg::MaskReset;
         pass_count_ff <= hss_pkg::PassReset;
      end else if (csr_we) begin
         unique case (csr_index)
            hss_pkg::CsrGridSide: grid_side_ff  <= csr_wdata;
            hss_pkg::CsrEdgeMask: edge_mask_ff  <= csr_wdata[hss_pkg::MaskW-1:0];
            hss_pkg::CsrPasses:   pass_count_ff <= csr_wdata[hss_pkg::PassW-1:0];
            default: ;
         endcase
      end
   end

   // Side in use, clamped to the legal range.
   logic [CmpW-1:0] side, side_m1, gs_ext, max_ext;
   assign gs_ext  = CmpW'(grid_side_ff);
   assign max_ext = CmpW'(MAX_SIDE);
   always_comb begin
      if (gs_ext < CmpW'(2)) begin
         side = CmpW'(2);
      end else if (gs_ext > max_ext) begin
         side = max_ext;
      end else begin
         side = gs_ext;
      end
   end
   assign side_m1 = side - CmpW'(1);

   // Captured request.
   hss_pkg::req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
   end

   logic [CmpW-1:0] col_ext, row_ext;
   logic            in_grid;
   logic [AW-1:0]   user_addr;
   assign col_ext   = CmpW'(req_ff.col);
   assign row_ext   = CmpW'(req_ff.row);
   assign in_grid   = (col_ext < side) && (row_ext < side);
   assign user_addr = {row_ext[CW-1:0], col_ext[CW-1:0]};

   // Cell, pass and window counters.
   logic [CW-1:0]             x_ff, y_ff;
   logic [1:0]                wx_ff, wy_ff;
   logic [hss_pkg::PassW-1:0] pass_ff;
   logic                      bank_ff;
   logic [CmpW-1:0]           x_ext, y_ext;
   logic                      x_last, y_last, win_last, pass_last;

   assign x_ext     = CmpW'(x_ff);
   assign y_ext     = CmpW'(y_ff);
   assign x_last    = (x_ext == side_m1);
   assign y_last    = (y_ext == side_m1);
   assign win_last  = (wx_ff == 2'd2) && (wy_ff == 2'd2);
   assign pass_last = ({1'b0, pass_ff} + 5'd1) == {1'b0, pass_count_ff};

   // Neighbor position and whether it lies inside the grid.
   logic [CW-1:0] nx, ny;
   logic          n_in, n_center;
   always_comb begin
      unique case (wx_ff)
         2'd0:    nx = x_ff - CW'(1);
         2'd2:    nx = x_ff + CW'(1);
         default: nx = x_ff;
      endcase
      unique case (wy_ff)
         2'd0:    ny = y_ff - CW'(1);
         2'd2:    ny = y_ff + CW'(1);
         default: ny = y_ff;
      endcase
      n_in = !((wx_ff == 2'd0) && (x_ff == '0)) && !((wx_ff == 2'd2) && x_last) &&
             !((wy_ff == 2'd0) && (y_ff == '0)) && !((wy_ff == 2'd2) && y_last);
      n_center = (wx_ff == 2'd1) && (wy_ff == 2'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         wx_ff   <= '0;
         wy_ff   <= '0;
         pass_ff <= '0;
         bank_ff <= 1'b0;
      end else if (cmd.run_init) begin
         x_ff    <= '0;
         y_ff    <= '0;
         wx_ff   <= '0;
         wy_ff   <= '0;
         pass_ff <= '0;
      end else if (cmd.win_read) begin
         // Step the window, column offset fastest.
         if (wx_ff == 2'd2) begin
            wx_ff <= '0;
            wy_ff <= win_last ? 2'd0 : wy_ff + 2'd1;
         end else begin
            wx_ff <= wx_ff + 2'd1;
         end
      end else if (cmd.write_back) begin
         // Step the cell; at the grid end swap banks and step the pass.
         if (x_last) begin
            x_ff <= '0;
            if (y_last) begin
               y_ff    <= '0;
               bank_ff <= !bank_ff;
               pass_ff <= pass_ff + 1'b1;
            end else begin
               y_ff <= y_ff + CW'(1);
            end
         end else begin
            x_ff <= x_ff + CW'(1);
         end
      end
   end

   // Grid banks: reads come from the current bank, pass results go to the
   // other one.
   logic [HW-1:0] mem0 [Depth];
   logic [HW-1:0] mem1 [Depth];
   logic [HW-1:0] rd0_ff, rd1_ff, rd_data;
   logic          rd_en, we, wbank;
   logic [AW-1:0] raddr, waddr;
   logic [HW-1:0] wdata;
   logic [HW-1:0] wb_value;

   assign rd_en = cmd.win_read || (cmd.user_exec && (req_ff.op == hss_pkg::OpRead));
   assign raddr = cmd.win_read ? {ny, nx} : user_addr;
   assign we    = cmd.write_back ||
                  (cmd.user_exec && (req_ff.op == hss_pkg::OpWrite) && in_grid);
   assign wbank = cmd.write_back ? !bank_ff : bank_ff;
   assign waddr = cmd.write_back ? {y_ff, x_ff} : user_addr;
   assign wdata = cmd.write_back ? wb_value : req_ff.height_in;

   always_ff @(posedge clock) begin
      if (we && !wbank) begin
         mem0[waddr] <= wdata;
      end
      if (rd_en) begin
         rd0_ff <= mem0[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (we && wbank) begin
         mem1[waddr] <= wdata;
      end
      if (rd_en) begin
         rd1_ff <= mem1[raddr];
      end
   end

   assign rd_data = bank_ff ? rd1_ff : rd0_ff;

   // Window accumulation, in the cycle after each read.
   logic            pv_ff, pc_ff;
   logic [HW-1:0]   c_ff;
   logic [SumW-1:0] s_ff;
   logic [3:0]      n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= cmd.win_read && n_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff <= n_center;
      if (cmd.run_init || cmd.write_back) begin
         c_ff <= '0;
         s_ff <= '0;
         n_ff <= '0;
      end else if (pv_ff) begin
         n_ff <= n_ff + 4'd1;
         if (pc_ff) begin
            c_ff <= rd_data;
         end else begin
            s_ff <= s_ff + SumW'(rd_data);
         end
      end
   end

   // Weighted numerator 15*n*c + 12*s, registered before the divide.
   logic [hss_pkg::DenW-1:0] own_k;
   logic [hss_pkg::NumW-1:0] num, num_ff;
   assign own_k = hss_pkg::DenW'(n_ff) * hss_pkg::DenW'(hss_pkg::KOwn);
   assign num   = hss_pkg::NumW'(own_k) * hss_pkg::NumW'(c_ff) +
                  hss_pkg::NumW'(s_ff) * hss_pkg::NumW'(hss_pkg::KNbr);

   // Division by 20*n as a multiply by the rounded-up reciprocal and a shift.
   // Each reciprocal errs by less than 2^(shift - NumW) / 180, so every quotient of
   // a NumW-bit numerator comes out exact.
   logic [hss_pkg::RecipW-1:0] recip;
   logic [hss_pkg::ProdW-1:0]  prod_ff;
   logic [hss_pkg::QuotW-1:0]  quot;
   always_comb begin
      unique case (n_ff)
         4'd4:    recip = hss_pkg::RecipCorner;
         4'd6:    recip = hss_pkg::RecipEdge;
         default: recip = hss_pkg::RecipInner;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         num_ff <= num;
      end
      if (cmd.div_step) begin
         prod_ff <= hss_pkg::ProdW'(num_ff) * hss_pkg::ProdW'(recip);
      end
   end
   assign quot = prod_ff[hss_pkg::ProdW-1:hss_pkg::RecipShift];

   // Result of the cell: fixed cells keep their value, others saturate.
   logic fixed, clip;
   assign fixed = (edge_mask_ff[hss_pkg::EdgeLeft]   && (x_ff == '0)) ||
                  (edge_mask_ff[hss_pkg::EdgeTop]    && y_last)       ||
                  (edge_mask_ff[hss_pkg::EdgeRight]  && x_last)       ||
                  (edge_mask_ff[hss_pkg::EdgeBottom] && (y_ff == '0));
   assign clip  = !fixed && (quot > hss_pkg::QuotW'(hss_pkg::HMax));
   always_comb begin
      if (fixed) begin
         wb_value = c_ff;
      end else if (clip) begin
         wb_value = hss_pkg::HMax;
      end else begin
         wb_value = quot[HW-1:0];
      end
   end

   logic clip_ff;
   always_ff @(posedge clock) begin
      if (reset || cmd.run_init) begin
         clip_ff <= 1'b0;
      end else if (cmd.write_back && clip) begin
         clip_ff <= 1'b1;
      end
   end

   // Response register.
   logic             rsp_valid_ff;
   hss_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.height_out <= ((req_ff.op == hss_pkg::OpRead) && in_grid) ? rd_data : '0;
         rsp_ff.saturated  <= clip_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status to the controller.
   assign status.op        = req_ff.op;
   assign status.pass_zero = (pass_count_ff == '0);
   assign status.win_last  = win_last;
   assign status.run_last  = x_last && y_last && pass_last;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

endmodule
